FILE: rtl/sdrs_pkg.sv
// Shared types and constants for the scene depth range scale unit.
package sdrs_pkg;

   // Field widths
   localparam int VERT_W   = 32;
   localparam int DIR_W    = 16;
   localparam int OFS_W    = 32;
   localparam int PROD_W   = VERT_W + DIR_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int FRAC_SH  = 14;
   localparam int DEPTH_W  = ACC_W - FRAC_SH;
   localparam int NEAR_W   = 34;
   localparam int SCALE_W  = 60;
   localparam int STATUS_W = 2;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   // Depth extremes and scale numerator (267175328 * 2^32)
   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
   localparam logic signed [DEPTH_W-1:0] DEPTH_EPS = DEPTH_W'(1);
   localparam logic [SCALE_W-1:0] SCALE_NUM = SCALE_W'(64'd267175328 << 32);

   // Reset values of the view setup
   localparam logic signed [DIR_W-1:0] DIR_Z_RESET = DIR_W'(16384);

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BEHIND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NARROW = 2'd2;

   // Register indexes
   typedef enum logic [2:0] {
      CSR_VIEW_DIR_X,
      CSR_VIEW_DIR_Y,
      CSR_VIEW_DIR_Z,
      CSR_CAMERA_OFFSET,
      CSR_SOLID_ONLY
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_UPDATE,
      ST_EVAL,
      ST_DIV
   } state_type;

   // Controls for the shared multiply-accumulate unit
   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic acc_first;
   } mac_ctl_type;

endpackage

FILE: rtl/scene_depth_range_scale_unit.sv
// Top level: sequencer, depth extremes, view registers and result word for the depth range unit.
// A vertex word keeps busy high through 4 multiply-accumulate steps on one shared multiplier
// and 1 extreme update, and a new vertex word is taken only once busy is low again. A last word
// adds an evaluate step; when the status is ok busy then stays high while the divider
// finds 60 quotient bits, one a cycle. The result word is on the rsp_ ports with rsp_valid in
// the cycle busy drops; the receiver cannot stall. Synchronous reset clears the sequencer, the
// extremes and the view registers to their defaults.
module scene_depth_range_scale_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // Command channel
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [sdrs_pkg::VERT_W-1:0]     req_vert_x,
   input  logic signed [sdrs_pkg::VERT_W-1:0]     req_vert_y,
   input  logic signed [sdrs_pkg::VERT_W-1:0]     req_vert_z,
   input  logic                                   req_transparent,
   input  logic                                   req_has_vertex,
   input  logic                                   req_last,
   // Result channel
   output logic                                   rsp_valid,
   output logic [sdrs_pkg::STATUS_W-1:0]          rsp_status,
   output logic [sdrs_pkg::NEAR_W-1:0]            rsp_near_offset,
   output logic [sdrs_pkg::SCALE_W-1:0]           rsp_depth_scale,
   // Register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [sdrs_pkg::CSR_AW-1:0]            paddr,
   input  logic [sdrs_pkg::CSR_DW-1:0]            pwdata,
   output logic [sdrs_pkg::CSR_DW-1:0]            prdata,
   output logic                                   pready
);
   import sdrs_pkg::*;

   state_type                 state_ff, state_in;
   logic [1:0]                step_ff, step_in;
   logic signed [VERT_W-1:0]  vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic                      last_ff, last_in;
   logic signed [DEPTH_W-1:0] near_ff, near_in, far_ff, far_in;
   logic [NEAR_W-1:0]         nr_ff, nr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic [NEAR_W-1:0]         offs_ff, offs_in;
   logic [SCALE_W-1:0]        scale_ff, scale_in;

   logic signed [DIR_W-1:0]   dir_x_ff, dir_x_in, dir_y_ff, dir_y_in, dir_z_ff, dir_z_in;
   logic signed [OFS_W-1:0]   cam_ofs_ff, cam_ofs_in;
   logic                      solid_ff, solid_in;

   mac_ctl_type               mac_ctl;
   logic signed [VERT_W-1:0]  op_a;
   logic signed [DIR_W-1:0]   op_b;
   logic signed [ACC_W-1:0]   acc;

   logic                      div_go;
   logic [DEPTH_W-1:0]        div_divisor;
   logic                      div_done;
   logic [SCALE_W-1:0]        div_quotient;

   logic                      accept;
   logic                      use_vertex;
   logic                      csr_write;
   csr_index_type             csr_index;
   logic signed [DEPTH_W-1:0] depth;
   logic signed [DEPTH_W-1:0] nr;
   logic signed [DEPTH_W:0]   range_wide;

   sdrs_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   sdrs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign use_vertex = req_has_vertex && !(solid_ff && req_transparent);

   // Depth of the summed dot product: floor shift, then camera offset
   assign depth = acc[ACC_W-1:FRAC_SH] + DEPTH_W'(cam_ofs_ff);

   // Near clamped to epsilon, and the range above it
   assign nr         = (near_ff < DEPTH_EPS) ? DEPTH_EPS : near_ff;
   assign range_wide = {far_ff[DEPTH_W-1], far_ff} - {nr[DEPTH_W-1], nr};
   assign div_divisor = range_wide[DEPTH_W-1:0];

   // Pick the operand pair for the current multiply step
   always_comb begin
      unique case (step_ff)
         2'd0: begin
            op_a = vx_ff;
            op_b = dir_x_ff;
         end
         2'd1: begin
            op_a = vy_ff;
            op_b = dir_y_ff;
         end
         default: begin
            op_a = vz_ff;
            op_b = dir_z_ff;
         end
      endcase
   end

   // Sequence the word: multiply-accumulate, update extremes, evaluate, divide
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      vz_in        = vz_ff;
      last_in      = last_ff;
      near_in      = near_ff;
      far_in       = far_ff;
      nr_in        = nr_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      offs_in      = offs_ff;
      scale_in     = scale_ff;
      mac_ctl      = '0;
      div_go       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               vx_in   = req_vert_x;
               vy_in   = req_vert_y;
               vz_in   = req_vert_z;
               last_in = req_last;
               step_in = 2'd0;
               if (use_vertex) begin
                  state_in = ST_MAC;
               end else if (req_last) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_MAC: begin
            mac_ctl.mul_en    = (step_ff != 2'd3);
            mac_ctl.acc_en    = (step_ff != 2'd0);
            mac_ctl.acc_first = (step_ff == 2'd1);
            step_in           = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (depth < near_ff) begin
               near_in = depth;
            end
            if (depth > far_ff) begin
               far_in = depth;
            end
            state_in = last_ff ? ST_EVAL : ST_IDLE;
         end
         ST_EVAL: begin
            priority if (far_ff < DEPTH_EPS) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_BEHIND;
               offs_in      = '0;
               scale_in     = '0;
               near_in      = DEPTH_MAX;
               far_in       = DEPTH_MIN;
               state_in     = ST_IDLE;
            end else if (range_wide < (DEPTH_W+1)'(1)) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_NARROW;
               offs_in      = '0;
               scale_in     = '0;
               near_in      = DEPTH_MAX;
               far_in       = DEPTH_MIN;
               state_in     = ST_IDLE;
            end else begin
               nr_in    = nr[NEAR_W-1:0];
               div_go   = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               offs_in      = nr_ff;
               scale_in     = div_quotient;
               near_in      = DEPTH_MAX;
               far_in       = DEPTH_MIN;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Register writes
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[CSR_AW-1:2]);

   always_comb begin
      dir_x_in   = dir_x_ff;
      dir_y_in   = dir_y_ff;
      dir_z_in   = dir_z_ff;
      cam_ofs_in = cam_ofs_ff;
      solid_in   = solid_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_VIEW_DIR_X:    dir_x_in   = pwdata[DIR_W-1:0];
            CSR_VIEW_DIR_Y:    dir_y_in   = pwdata[DIR_W-1:0];
            CSR_VIEW_DIR_Z:    dir_z_in   = pwdata[DIR_W-1:0];
            CSR_CAMERA_OFFSET: cam_ofs_in = pwdata[OFS_W-1:0];
            CSR_SOLID_ONLY:    solid_in   = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_index)
         CSR_VIEW_DIR_X:    prdata = CSR_DW'(dir_x_ff);
         CSR_VIEW_DIR_Y:    prdata = CSR_DW'(dir_y_ff);
         CSR_VIEW_DIR_Z:    prdata = CSR_DW'(dir_z_ff);
         CSR_CAMERA_OFFSET: prdata = CSR_DW'(cam_ofs_ff);
         CSR_SOLID_ONLY:    prdata = CSR_DW'(solid_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         near_ff      <= DEPTH_MAX;
         far_ff       <= DEPTH_MIN;
         rsp_valid_ff <= 1'b0;
         dir_x_ff     <= '0;
         dir_y_ff     <= '0;
         dir_z_ff     <= DIR_Z_RESET;
         cam_ofs_ff   <= '0;
         solid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         near_ff      <= near_in;
         far_ff       <= far_in;
         rsp_valid_ff <= rsp_valid_in;
         dir_x_ff     <= dir_x_in;
         dir_y_ff     <= dir_y_in;
         dir_z_ff     <= dir_z_in;
         cam_ofs_ff   <= cam_ofs_in;
         solid_ff     <= solid_in;
      end
      step_ff   <= step_in;
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      vz_ff     <= vz_in;
      last_ff   <= last_in;
      nr_ff     <= nr_in;
      status_ff <= status_in;
      offs_ff   <= offs_in;
      scale_ff  <= scale_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_near_offset = offs_ff;
   assign rsp_depth_scale = scale_ff;

endmodule

FILE: rtl/sdrs_mac.sv
// Shared multiply-accumulate unit: one 32x16 product per cycle while mul_en is set, summed over steps.
module sdrs_mac (
   input  logic                                   clock,
   input  sdrs_pkg::mac_ctl_type                  ctl,
   input  logic signed [sdrs_pkg::VERT_W-1:0]     op_a,
   input  logic signed [sdrs_pkg::DIR_W-1:0]      op_b,
   output logic signed [sdrs_pkg::ACC_W-1:0]      acc
);
   import sdrs_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;

   // Multiply, then sum the registered product
   always_comb begin
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      prod_ext = ACC_W'(prod_ff);
      if (ctl.mul_en) begin
         prod_in = op_a * op_b;
      end
      if (ctl.acc_en) begin
         acc_in = ctl.acc_first ? prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/sdrs_div.sv
// Restoring divider: the scale numerator over the depth range, one quotient bit a cycle.
module sdrs_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  logic [sdrs_pkg::DEPTH_W-1:0]         divisor,
   output logic                                 done,
   output logic [sdrs_pkg::SCALE_W-1:0]         quotient
);
   import sdrs_pkg::*;

   localparam int CNT_W = $clog2(SCALE_W);

   logic [DEPTH_W-1:0] rem_ff, rem_in;
   logic [SCALE_W-1:0] quo_ff, quo_in;
   logic [DEPTH_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [DEPTH_W:0]   shifted;
   logic [DEPTH_W+1:0] trial;

   // Shift in one numerator bit and try the subtract
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[SCALE_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      if (go) begin
         rem_in = '0;
         quo_in = SCALE_NUM;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[DEPTH_W+1]) begin
            rem_in = trial[DEPTH_W-1:0];
            quo_in = {quo_ff[SCALE_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEPTH_W-1:0];
            quo_in = {quo_ff[SCALE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(SCALE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: dv/testbench.sv
// Testbench for the scene depth range scale unit: directed and random scenes vs. a local predictor.
`timescale 1ns / 1ps

module testbench;
   import sdrs_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_WORDS = 1725;
   localparam logic signed [VERT_W-1:0] VERT_MAX = {1'b0, {(VERT_W-1){1'b1}}};
   localparam logic signed [VERT_W-1:0] VERT_MIN = {1'b1, {(VERT_W-1){1'b0}}};

   typedef struct {
      logic signed [VERT_W-1:0] x;
      logic signed [VERT_W-1:0] y;
      logic signed [VERT_W-1:0] z;
      logic                     transparent;
      logic                     has_vertex;
      logic                     last;
   } vertex_word_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [NEAR_W-1:0]   near_offset;
      logic [SCALE_W-1:0]  depth_scale;
   } depth_bounds_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic signed [VERT_W-1:0]    req_vert_x;
   logic signed [VERT_W-1:0]    req_vert_y;
   logic signed [VERT_W-1:0]    req_vert_z;
   logic                        req_transparent;
   logic                        req_has_vertex;
   logic                        req_last;
   logic                        rsp_valid;
   logic [STATUS_W-1:0]         rsp_status;
   logic [NEAR_W-1:0]           rsp_near_offset;
   logic [SCALE_W-1:0]          rsp_depth_scale;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [CSR_AW-1:0]           paddr;
   logic [CSR_DW-1:0]           pwdata;
   logic [CSR_DW-1:0]           prdata;
   logic                        pready;

   // Local copy of the view setup and the running scene extremes
   logic signed [DIR_W-1:0]     cfg_dir_x;
   logic signed [DIR_W-1:0]     cfg_dir_y;
   logic signed [DIR_W-1:0]     cfg_dir_z;
   logic signed [OFS_W-1:0]     cfg_cam_offset;
   logic                        cfg_solid_only;
   longint                      scene_near;
   longint                      scene_far;

   depth_bounds_type            pending_bounds[$];
   int                          mismatch_count = 0;
   int                          counted_words = 0;
   int                          idle_pct = 22;
   int                          idle_cycles = 0;

   scene_depth_range_scale_unit dut (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Fold one word into the scene extremes; close the scene on last
   task automatic predict_depth_bounds(input vertex_word_type w);
      longint           dot;
      longint           depth;
      longint           near_clamped;
      longint           span;
      depth_bounds_type res;
      if (w.has_vertex && !(cfg_solid_only && w.transparent)) begin
         dot = longint'(w.x) * longint'(cfg_dir_x) + longint'(w.y) * longint'(cfg_dir_y)
             + longint'(w.z) * longint'(cfg_dir_z);
         depth = (dot >>> FRAC_SH) + longint'(cfg_cam_offset);
         if (depth < scene_near) scene_near = depth;
         if (depth > scene_far) scene_far = depth;
      end
      if (w.last) begin
         res.near_offset = '0;
         res.depth_scale = '0;
         if (scene_far < longint'(DEPTH_EPS)) begin
            res.status = STATUS_BEHIND;
         end else begin
            near_clamped = (scene_near < longint'(DEPTH_EPS)) ? longint'(DEPTH_EPS) : scene_near;
            span = scene_far - near_clamped;
            if (span < 1) begin
               res.status = STATUS_NARROW;
            end else begin
               res.status      = STATUS_OK;
               res.near_offset = near_clamped[NEAR_W-1:0];
               res.depth_scale = SCALE_W'(64'(SCALE_NUM) / $unsigned(span));
            end
         end
         pending_bounds.push_back(res);
         scene_near = longint'(DEPTH_MAX);
         scene_far  = longint'(DEPTH_MIN);
      end
   endtask

   function automatic vertex_word_type vword(input logic signed [VERT_W-1:0] x, y, z,
                                             input logic transparent, has_vertex, last);
      vertex_word_type w;
      w.x = x;
      w.y = y;
      w.z = z;
      w.transparent = transparent;
      w.has_vertex  = has_vertex;
      w.last        = last;
      return w;
   endfunction

   // Idle at random, then hold the word with start high until it is taken
   task automatic send_vertex_word(input vertex_word_type w);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_vert_x      <= w.x;
      req_vert_y      <= w.y;
      req_vert_z      <= w.z;
      req_transparent <= w.transparent;
      req_has_vertex  <= w.has_vertex;
      req_last        <= w.last;
      start           <= 1'b1;
      do begin
         @(posedge clock);
      end while (busy);
      predict_depth_bounds(w);
      counted_words++;
   endtask

   // Drop start and hold off until every pending result has come back
   task automatic drain_results();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_bounds.size() != 0);
   endtask

   // Write one register over the bus, then read it back
   task automatic write_register(input csr_index_type idx, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] mask;
      case (idx)
         CSR_VIEW_DIR_X: begin
            cfg_dir_x = value[DIR_W-1:0];
            mask = CSR_DW'((1 << DIR_W) - 1);
         end
         CSR_VIEW_DIR_Y: begin
            cfg_dir_y = value[DIR_W-1:0];
            mask = CSR_DW'((1 << DIR_W) - 1);
         end
         CSR_VIEW_DIR_Z: begin
            cfg_dir_z = value[DIR_W-1:0];
            mask = CSR_DW'((1 << DIR_W) - 1);
         end
         CSR_CAMERA_OFFSET: begin
            cfg_cam_offset = value[OFS_W-1:0];
            mask = '1;
         end
         default: begin
            cfg_solid_only = value[0];
            mask = CSR_DW'(1);
         end
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      // read phase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      if ((prdata & mask) !== (value & mask)) begin
         $display("%0t: register %s readback expected %h actual %h", $time, idx.name(),
                  value & mask, prdata & mask);
         mismatch_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Quiesce the block, then load a full view setup
   task automatic set_view(input logic signed [DIR_W-1:0] dx, dy, dz,
                           input logic signed [OFS_W-1:0] cam, input logic solid);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
      write_register(CSR_VIEW_DIR_X, CSR_DW'(dx));
      write_register(CSR_VIEW_DIR_Y, CSR_DW'(dy));
      write_register(CSR_VIEW_DIR_Z, CSR_DW'(dz));
      write_register(CSR_CAMERA_OFFSET, CSR_DW'(cam));
      write_register(CSR_SOLID_ONLY, CSR_DW'(solid));
   endtask

   function automatic logic signed [VERT_W-1:0] rand_coord();
      case ($urandom_range(9))
         0, 1, 2, 3: return VERT_W'($urandom);
         4, 5, 6:    return VERT_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         7:          return VERT_W'(int'($urandom_range(0, 8)) - 4);
         8:          return $urandom_range(1) ? VERT_MAX : VERT_MIN;
         default:    return VERT_W'($urandom & 32'h0000_ffff);
      endcase
   endfunction

   function automatic logic signed [DIR_W-1:0] rand_dir();
      case ($urandom_range(9))
         0:       return -DIR_W'(16384);
         1:       return DIR_W'(16384);
         2:       return '0;
         3:       return $urandom_range(1) ? DIR_W'(32767) : DIR_W'(-32768);
         default: return DIR_W'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic signed [OFS_W-1:0] rand_offset();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return OFS_W'($urandom);
         6:                return OFS_W'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
         7:                return {1'b0, {(OFS_W-1){1'b1}}};
         8:                return {1'b1, {(OFS_W-1){1'b0}}};
         default:          return '0;
      endcase
   endfunction

   // Status cases under the reset view: empty, behind, clamped near, narrow, ok
   task automatic test_scene_status_cases();
      send_vertex_word(vword(0, 0, 0, 0, 0, 1));
      send_vertex_word(vword(-1, 1, 5, 0, 1, 1));
      send_vertex_word(vword(0, 0, 1, 0, 1, 0));
      send_vertex_word(vword(0, 0, 2, 0, 1, 1));
      send_vertex_word(vword(0, 0, -3, 0, 1, 0));
      send_vertex_word(vword(0, 0, 1, 0, 1, 1));
      send_vertex_word(vword(0, 0, -7, 0, 1, 0));
      send_vertex_word(vword(0, 0, 100, 0, 1, 0));
      send_vertex_word(vword(0, 0, 0, 0, 0, 1));
      send_vertex_word(vword(0, 0, 0, 0, 1, 1));
      send_vertex_word(vword(0, 0, 0, 0, 0, 0));
      send_vertex_word(vword(VERT_MIN, VERT_MAX, VERT_MIN, 1, 1, 0));
      send_vertex_word(vword(VERT_MAX, VERT_MIN, VERT_MAX, 0, 1, 1));
   endtask

   // Solid-only mode: transparent vertices must not move the extremes
   task automatic test_solid_only_filter();
      set_view(0, 0, DIR_Z_RESET, 0, 1'b1);
      send_vertex_word(vword(0, 0, 3, 1, 1, 0));
      send_vertex_word(vword(0, 0, 50, 0, 1, 0));
      send_vertex_word(vword(0, 0, 60, 0, 1, 0));
      send_vertex_word(vword(0, 0, 1000, 1, 1, 1));
      send_vertex_word(vword(0, 0, 9, 1, 1, 0));
      send_vertex_word(vword(0, 0, 9, 1, 1, 1));
   endtask

   // Direction and offset extremes, including directions past unit length
   task automatic test_view_extremes();
      set_view(-DIR_W'(16384), DIR_W'(16384), -DIR_W'(16384), {1'b0, {(OFS_W-1){1'b1}}}, 1'b0);
      send_vertex_word(vword(VERT_MIN, VERT_MAX, VERT_MIN, 0, 1, 0));
      send_vertex_word(vword(VERT_MAX, VERT_MIN, VERT_MAX, 0, 1, 1));
      set_view(DIR_W'(32767), DIR_W'(-32768), DIR_W'(32767), {1'b1, {(OFS_W-1){1'b0}}}, 1'b0);
      send_vertex_word(vword(VERT_MAX, VERT_MIN, VERT_MAX, 0, 1, 0));
      send_vertex_word(vword(VERT_MIN, VERT_MAX, VERT_MIN, 1, 1, 0));
      send_vertex_word(vword(0, 0, 0, 0, 1, 1));
   endtask

   // Random scenes over several view setups; one phase never idles
   task automatic test_random_scenes();
      int              target;
      int              phase_start;
      int              scene_len;
      bit              last_with_vertex;
      vertex_word_type w;
      vertex_word_type prev;
      target = counted_words + RANDOM_WORDS;
      prev = vword(0, 0, 0, 0, 1, 0);
      for (int phase = 0; counted_words < target; phase++) begin
         set_view(rand_dir(), rand_dir(), rand_dir(), rand_offset(), 1'($urandom_range(1)));
         idle_pct = (phase == 1) ? 0 : 22;
         phase_start = counted_words;
         while (counted_words - phase_start < 300 && counted_words < target) begin
            scene_len = ($urandom_range(3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
            last_with_vertex = $urandom_range(1);
            for (int i = 0; i < scene_len; i++) begin
               if ($urandom_range(19) == 0) begin
                  // noise: neither vertex nor end of scene
                  send_vertex_word(vword(rand_coord(), rand_coord(), rand_coord(),
                                         1'($urandom_range(1)), 0, 0));
               end
               if ($urandom_range(99) < 15) begin
                  w = prev;
               end else begin
                  w = vword(rand_coord(), rand_coord(), rand_coord(), 0, 1, 0);
               end
               w.transparent = $urandom_range(1);
               w.has_vertex  = 1'b1;
               w.last        = last_with_vertex && (i == scene_len - 1);
               send_vertex_word(w);
               prev = w;
            end
            if (!(last_with_vertex && scene_len > 0)) begin
               send_vertex_word(vword(rand_coord(), rand_coord(), rand_coord(),
                                      1'($urandom_range(1)), 0, 1));
            end
            if ($urandom_range(29) == 0) drain_results();
         end
      end
   endtask

   // Check each result word against the oldest pending prediction
   always @(posedge clock) begin : check_bounds
      depth_bounds_type want;
      if (!reset && rsp_valid) begin
         if (pending_bounds.size() == 0) begin
            $display("%0t: unexpected result expected none actual status %0d near %0d scale %0d",
                     $time, rsp_status, rsp_near_offset, rsp_depth_scale);
            mismatch_count++;
         end else begin
            want = pending_bounds.pop_front();
            if (rsp_status !== want.status || rsp_near_offset !== want.near_offset ||
                rsp_depth_scale !== want.depth_scale) begin
               $display("%0t: result expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                        want.status, want.near_offset, want.depth_scale,
                        rsp_status, rsp_near_offset, rsp_depth_scale);
               mismatch_count++;
            end
         end
      end
   end

   // Count cycles with no traffic at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_vert_x      <= '0;
      req_vert_y      <= '0;
      req_vert_z      <= '0;
      req_transparent <= 1'b0;
      req_has_vertex  <= 1'b0;
      req_last        <= 1'b0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      cfg_dir_x       = '0;
      cfg_dir_y       = '0;
      cfg_dir_z       = DIR_Z_RESET;
      cfg_cam_offset  = '0;
      cfg_solid_only  = 1'b0;
      scene_near      = longint'(DEPTH_MAX);
      scene_far       = longint'(DEPTH_MIN);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_scene_status_cases();
      test_solid_only_filter();
      test_view_extremes();
      test_random_scenes();
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
